/* sv/tgaenc_pkg.sv */
// Shared types, constants and byte tables of the TGA truecolor stream encoder.
package tgaenc_pkg;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_PIXEL  = 2'd1,
    MODE_FINISH = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_ALPHA_EN     = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_PIXEL  = 2'd1,
    CMD_FOOTER = 2'd2
  } cmd_kind_t;

  // One classified command; data is the pixel word, or the pixel count for a footer.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] data;
  } cmd_t;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [4:0] HDR_LAST       = 5'd17;
  localparam logic [4:0] FTR_LAST       = 5'd25;
  localparam logic [4:0] FTR_PAD        = 5'd8;
  localparam logic [4:0] PIX_LAST_BGR   = 5'd2;
  localparam logic [4:0] PIX_LAST_BGRA  = 5'd3;
  localparam logic [7:0] HDR_IMAGE_TYPE = 8'd2;
  localparam logic [7:0] BPP_ALPHA      = 8'd32;
  localparam logic [7:0] BPP_NO_ALPHA   = 8'd24;
  localparam logic [31:0] COUNT_SAT     = 32'hFFFF_FFFF;

  function automatic logic [7:0] hdr_byte(input logic [4:0] idx, input logic [15:0] w,
                                          input logic [15:0] h, input logic alpha);
    logic [7:0] b;
    case (idx)
      5'd2:    b = HDR_IMAGE_TYPE;
      5'd12:   b = w[7:0];
      5'd13:   b = w[15:8];
      5'd14:   b = h[7:0];
      5'd15:   b = h[15:8];
      5'd16:   b = alpha ? BPP_ALPHA : BPP_NO_ALPHA;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // "TRUEVISION-XFILE." followed by nul
  function automatic logic [7:0] sig_byte(input logic [4:0] k);
    logic [7:0] b;
    case (k)
      5'd0:    b = 8'h54;
      5'd1:    b = 8'h52;
      5'd2:    b = 8'h55;
      5'd3:    b = 8'h45;
      5'd4:    b = 8'h56;
      5'd5:    b = 8'h49;
      5'd6:    b = 8'h53;
      5'd7:    b = 8'h49;
      5'd8:    b = 8'h4F;
      5'd9:    b = 8'h4E;
      5'd10:   b = 8'h2D;
      5'd11:   b = 8'h58;
      5'd12:   b = 8'h46;
      5'd13:   b = 8'h49;
      5'd14:   b = 8'h4C;
      5'd15:   b = 8'h45;
      5'd16:   b = 8'h2E;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* sv/tgaenc_front.sv */
// Front end: accepts input transfers, keeps the pixel count, pushes commands.
module tgaenc_front import tgaenc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] pixel,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic [31:0] pixel_total;
  logic [31:0] pixel_total_next;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    q_push           = 1'b0;
    q_cmd.kind       = CMD_HEADER;
    q_cmd.data       = pixel;
    pixel_total_next = pixel_total;
    case (mode)
      MODE_START: begin
        q_push           = accept;
        pixel_total_next = '0;
      end
      MODE_PIXEL: begin
        q_push     = accept;
        q_cmd.kind = CMD_PIXEL;
        if (pixel_total != COUNT_SAT) begin
          pixel_total_next = pixel_total + 32'd1;
        end
      end
      MODE_FINISH: begin
        q_push     = accept;
        q_cmd.kind = CMD_FOOTER;
        q_cmd.data = pixel_total;
      end
      default: begin
        // unused mode: taken and dropped
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_total <= '0;
    end else if (accept) begin
      pixel_total <= pixel_total_next;
    end
  end

endmodule

/* sv/tgaenc_queue.sv */
// Small command queue between front and back ends.
module tgaenc_queue import tgaenc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t pop_cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* sv/tgaenc_back.sv */
// Back end: config registers and the byte sequencer feeding the output register.
module tgaenc_back import tgaenc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        q_not_empty,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        count_error
);

  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        alpha_en;
  logic [31:0] expect_total;

  logic        busy;
  cmd_kind_t   kind;
  logic [31:0] data;
  logic        err;
  logic [4:0]  idx;

  logic        can_emit;
  logic        cur_last;
  logic [4:0]  last_idx;
  logic [7:0]  cur_byte;
  logic        load;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= '0;
      image_height <= '0;
      alpha_en     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_ALPHA_EN:     alpha_en     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // width*height, registered; the user must keep config static while items flow, the block does not enforce it
  always_ff @(posedge clk) begin
    expect_total <= {16'h0000, image_width} * {16'h0000, image_height};
  end

  always_comb begin
    case (kind)
      CMD_HEADER: last_idx = HDR_LAST;
      CMD_PIXEL:  last_idx = alpha_en ? PIX_LAST_BGRA : PIX_LAST_BGR;
      default:    last_idx = FTR_LAST;
    endcase
  end

  always_comb begin
    case (kind)
      CMD_HEADER: cur_byte = hdr_byte(idx, image_width, image_height, alpha_en);
      CMD_PIXEL: begin
        case (idx[1:0])
          2'd0:    cur_byte = data[23:16];
          2'd1:    cur_byte = data[15:8];
          2'd2:    cur_byte = data[7:0];
          default: cur_byte = data[31:24];
        endcase
      end
      default: cur_byte = (idx < FTR_PAD) ? 8'h00 : sig_byte(idx - FTR_PAD);
    endcase
  end

  assign can_emit = !out_valid || !out_stall;
  assign cur_last = (idx == last_idx);
  assign load     = q_not_empty && (!busy || (can_emit && cur_last));
  assign q_pop    = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (busy && can_emit) begin
        out_valid <= 1'b1;
      end else if (can_emit) begin
        out_valid <= 1'b0;
      end
      // a new command takes over right behind the last byte of the current one
      if (load) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy && can_emit) begin
        idx <= idx + 5'd1;
        if (cur_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && can_emit) begin
      out_byte    <= cur_byte;
      last_of_run <= cur_last;
      count_error <= (kind == CMD_FOOTER) && err;
    end
    if (load) begin
      kind <= q_cmd.kind;
      data <= q_cmd.data;
      err  <= (q_cmd.data != expect_total);
    end
  end

endmodule

/* sv/tga_truecolor_stream_encoder.sv */
// Top level of the uncompressed truecolor TGA stream encoder.
//
// Input channel (in_valid/in_stall, mode, pixel): one command per transfer.
//   start  -> 18 header bytes (type 2, LE width/height, 24 or 32 bpp)
//   pixel  -> B,G,R or B,G,R,A from a packed RGBA word
//   finish -> 26 footer bytes: 8 zeros, "TRUEVISION-XFILE." and a nul
//   mode 3 is taken and dropped, no output.
// Output channel (out_valid/out_stall): one byte per transfer; last_of_run
//   marks the final byte of each command, count_error is set on every footer
//   byte when the pixel count since the last start differs from width*height.
// Config: cfg_we writes register cfg_index (0 width, 1 height, 2 alpha) from
//   cfg_data; write only while the encoder is idle.
// Path: the first byte of a command passes the queue, the sequencer's command
//   register and the output register before it is valid.
//   Throughput is set by the back-end byte sequencer, one byte per cycle while
//   out_stall is low; a queued command follows right behind the last byte.
// Reset clears the queue, the sequencer, the pixel count and the config
//   (alpha on, width and height zero). A stalled receiver freezes the output
//   register; the front keeps taking commands until the queue fills, then
//   raises in_stall.
module tga_truecolor_stream_encoder import tgaenc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        count_error
);

  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  logic q_not_empty;
  cmd_t q_pop_cmd;

  // classify and count
  tgaenc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .pixel    (pixel),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd)
  );

  // decouples command intake from byte output
  tgaenc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_cmd   (q_pop_cmd)
  );

  // serialize bytes
  tgaenc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_not_empty (q_not_empty),
    .q_cmd       (q_pop_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .count_error (count_error)
  );

endmodule

/* sv/tgaenc_checker.sv */
// Port-level assertions for the TGA stream encoder, bound to the top level.
module tgaenc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        last_of_run,
  input logic        count_error
);

  a_reset_out_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_reset_in_open: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("in_stall high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(last_of_run) && $stable(count_error))
    else $error("stalled output changed");

  a_footer_nul: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run && count_error |-> out_byte == 8'h00)
    else $error("footer does not end in nul");

endmodule

bind tga_truecolor_stream_encoder tgaenc_checker u_tgaenc_checker (.*);
